// ----- hw/rtl/gnm_pkg.sv -----
// ----------------------------------------------------------------------------
// gnm_pkg
// Shared types and codes for the glob automaton matcher.
// ----------------------------------------------------------------------------
package gnm_pkg;

  localparam int CP_W = 21;
  localparam logic [CP_W-1:0] SLASH_CP = 21'h00002F;

  typedef enum logic [1:0] {
    ITEM_LOAD_NODE  = 2'd0,
    ITEM_LOAD_RANGE = 2'd1,
    ITEM_BEGIN      = 2'd2,
    ITEM_CHAR       = 2'd3
  } item_kind_t;

  typedef enum logic [2:0] {
    NK_LITERAL = 3'd0,
    NK_ANY     = 3'd1,
    NK_STAR    = 3'd2,
    NK_RSTAR   = 3'd3,
    NK_SET     = 3'd4,
    NK_ACCEPT  = 3'd5,
    NK_EMPTY   = 3'd6,
    NK_BRANCH  = 3'd7
  } node_kind_t;

  typedef enum logic [1:0] {
    COVER_NONE = 2'd0,
    COVER_SOME = 2'd1,
    COVER_ALL  = 2'd2
  } cover_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLOS  = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_RNG   = 7'b0001000,
    ST_FOLD  = 7'b0010000,
    ST_COVER = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

endpackage

// ----- hw/rtl/glob_nfa_matcher.sv -----
// ----------------------------------------------------------------------------
// glob_nfa_matcher
// Steps a precompiled path-glob automaton over a stream of code points.
// ----------------------------------------------------------------------------
// Channel | Direction | Beat contents
// in_     | slave     | tdata: kind, node_index, node_kind, code_point,
//         |           |   next_node, negated, range_count, range_slot,
//         |           |   range_last, closure_plain, closure_component_start
// out_    | master    | tdata: accepted, cover_res
// cfg_    | write     | start_node
//
// Sequence: a load or begin beat passes a prime state, a cover scan of one
// node a cycle and an output state that raises its result. A character beat
// passes the prime state, then a scan of every node that also walks the
// ranges of each live set node with ranges, then a fold, before the cover
// scan and the output state. Reset clears the live set, accept mask, start
// node and control; memories are not cleared. A result beat waits in its
// register while out_tready is low; no new beat is taken until it has left.
// ----------------------------------------------------------------------------
module glob_nfa_matcher
  import gnm_pkg::*;
#(
  parameter int NODES           = 64,
  parameter int RANGES_PER_NODE = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // kind[1:0], node_index[7:2], node_kind[10:8], code_point[31:11],
  // next_node[37:32], negated[38], range_count[41:39], range_slot[43:42],
  // range_last[64:44], closure_plain[128:65], closure_component_start[192:129]
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accepted[0], cover_res[2:1]
  output logic [7:0]   out_tdata,
  input  logic         cfg_we,
  input  logic [5:0]   cfg_wdata
);

  localparam int NW = $clog2(NODES);
  localparam int RW = (RANGES_PER_NODE > 1) ? $clog2(RANGES_PER_NODE) : 1;
  localparam int CW = $clog2(RANGES_PER_NODE + 1);
  localparam int AW = NW + RW;

  // Unpack the input beat
  logic [1:0]  f_kind;
  logic [5:0]  f_idx, f_next;
  logic [2:0]  f_nkind, f_rcount;
  logic [20:0] f_cp, f_rlast;
  logic        f_neg;
  logic [1:0]  f_slot;
  logic [63:0] f_cplain, f_cstart;
  assign f_kind   = in_tdata[1:0];
  assign f_idx    = in_tdata[7:2];
  assign f_nkind  = in_tdata[10:8];
  assign f_cp     = in_tdata[31:11];
  assign f_next   = in_tdata[37:32];
  assign f_neg    = in_tdata[38];
  assign f_rcount = in_tdata[41:39];
  assign f_slot   = in_tdata[43:42];
  assign f_rlast  = in_tdata[64:44];
  assign f_cplain = in_tdata[128:65];
  assign f_cstart = in_tdata[192:129];

  // Node memory: kind, char, successor, negation, count
  typedef struct packed {
    logic [2:0]    kind;
    logic [20:0]   chr;
    logic [5:0]    succ;
    logic          neg;
    logic [CW-1:0] cnt;
  } node_t;

  node_t       node_mem [NODES];
  logic [NODES-1:0] pc_mem [NODES];
  logic [NODES-1:0] sc_mem [NODES];
  logic [41:0] rng_mem [NODES*(2**RW)];

  state_t           state_r, state_nxt;
  logic [NODES-1:0] active_r, next_r, accmask_r;
  logic [5:0]       start_r;
  logic [20:0]      cp_r;
  item_kind_t       kind_r;
  logic [NW-1:0]    i_r;
  logic [CW-1:0]    r_r;
  logic             hit_r;
  logic             clos_pend_r;
  logic             cov_pend_r;
  logic             covered_r;
  logic             acc_r;
  logic [1:0]       cov_r;
  logic             ovalid_r;

  // Memory read ports (addresses and registered data)
  logic [NW-1:0] nrd_addr;
  node_t         nrd_q;
  logic [NW-1:0] crd_addr;
  logic [NODES-1:0] pc_q, sc_q;
  logic [AW-1:0] rrd_addr;
  logic [41:0]   rrd_q;

  logic          accept_in;
  logic [CW-1:0] cnt_sat;
  logic [RW-1:0] slot_w;
  assign accept_in = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE) && !ovalid_r;
  assign cnt_sat = (32'(f_rcount) > RANGES_PER_NODE) ? CW'(RANGES_PER_NODE)
                                                      : CW'(f_rcount);
  assign slot_w  = RW'(f_slot);

  // Write memories on load beats
  always_ff @(posedge clk) begin
    if (accept_in && f_kind == ITEM_LOAD_NODE && 32'(f_idx) < NODES) begin
      node_mem[NW'(f_idx)] <= '{kind: f_nkind, chr: f_cp, succ: f_next,
                                neg: f_neg, cnt: cnt_sat};
      pc_mem[NW'(f_idx)]   <= NODES'(f_cplain);
      sc_mem[NW'(f_idx)]   <= NODES'(f_cstart);
    end
    if (accept_in && f_kind == ITEM_LOAD_RANGE && 32'(f_idx) < NODES &&
        32'(f_slot) < RANGES_PER_NODE) begin
      rng_mem[{NW'(f_idx), slot_w}] <= {f_rlast, f_cp};
    end
    nrd_q <= node_mem[nrd_addr];
    pc_q  <= pc_mem[crd_addr];
    sc_q  <= sc_mem[crd_addr];
    rrd_q <= rng_mem[rrd_addr];
  end

  // Current node fields and match decision (node data valid in scan states)
  logic [NW-1:0] cur;
  logic          sep, live, m, stay, cfirst_ok, in_rng;
  logic          set_walk, r_done, set_hit;
  logic [20:0]   rf, rl;
  assign cur  = i_r;
  assign sep  = (cp_r == SLASH_CP);
  assign live = active_r[cur];
  assign rf   = rrd_q[20:0];
  assign rl   = rrd_q[41:21];
  assign in_rng = (cp_r >= rf) && (cp_r <= rl);
  assign stay = (nrd_q.kind == NK_STAR) || (nrd_q.kind == NK_RSTAR);
  always_comb begin
    case (nrd_q.kind)
      NK_LITERAL: m = (cp_r == nrd_q.chr);
      NK_ANY, NK_STAR: m = !sep;
      NK_RSTAR: m = 1'b1;
      // set with no ranges: only a negated one matches
      NK_SET: m = !sep && nrd_q.neg;
      default: m = 1'b0;
    endcase
  end
  assign cfirst_ok = 32'(nrd_q.succ) < NODES;
  assign set_walk  = live && nrd_q.kind == NK_SET && nrd_q.cnt != '0;
  assign r_done    = (r_r == nrd_q.cnt - 1'b1);
  assign set_hit   = !sep && ((hit_r || in_rng) != nrd_q.neg);

  // Closure and cover fetches, node advance
  logic clos_fetch, cov_fetch, step, cov_hit;
  assign clos_fetch = (state_r == ST_SCAN && !set_walk && live && m &&
                       (stay || cfirst_ok)) ||
                      (state_r == ST_RNG && r_done && set_hit && cfirst_ok);
  assign cov_fetch  = state_r == ST_COVER && live && nrd_q.kind == NK_RSTAR &&
                      cfirst_ok;
  assign step       = (state_r == ST_SCAN && !set_walk) ||
                      (state_r == ST_RNG && r_done) || state_r == ST_COVER;
  assign cov_hit    = cov_pend_r && ((sc_q & accmask_r) != '0);

  // Read addresses: prefetch the next node when advancing
  always_comb begin
    nrd_addr = '0;
    if (step) nrd_addr = i_r + 1'b1;
    else if (state_r == ST_SCAN || state_r == ST_RNG) nrd_addr = i_r;
    rrd_addr = {i_r, {RW{1'b0}}};
    if (state_r == ST_RNG) rrd_addr = {i_r, RW'(r_r + 1'b1)};
    crd_addr = start_r[NW-1:0];
    if (state_r == ST_SCAN || state_r == ST_RNG)
      crd_addr = stay ? i_r : nrd_q.succ[NW-1:0];
    else if (state_r == ST_COVER)
      crd_addr = nrd_q.succ[NW-1:0];
  end

  // Control sequencer
  logic          last_node;
  assign last_node = (i_r == NW'(NODES - 1));

  logic [NODES-1:0] clos_sel;
  assign clos_sel = sep ? sc_q : pc_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; active_r <= '0; accmask_r <= '0; start_r <= '0;
      ovalid_r <= 1'b0; clos_pend_r <= 1'b0; cov_pend_r <= 1'b0;
      i_r <= '0; r_r <= '0; acc_r <= 1'b0; cov_r <= COVER_NONE;
    end else begin
      state_r     <= state_nxt;
      clos_pend_r <= clos_fetch;
      cov_pend_r  <= cov_fetch;
      if (cfg_we) start_r <= cfg_wdata;
      // raise the result beat, drop it once taken
      if (state_r == ST_OUT) ovalid_r <= 1'b1;
      else if (out_tvalid && out_tready) ovalid_r <= 1'b0;
      // advance the node index
      if (state_r == ST_IDLE || state_r == ST_CLOS || state_r == ST_FOLD) i_r <= '0;
      else if (step) i_r <= i_r + 1'b1;
      // walk the ranges of a live set node
      if (state_r == ST_RNG && !r_done) r_r <= r_r + 1'b1;
      else r_r <= '0;
      if (state_r == ST_RNG) hit_r <= hit_r || in_rng;
      else hit_r <= 1'b0;
      // fold in a closure fetched last cycle
      if (accept_in) next_r <= '0;
      else if (clos_pend_r) next_r <= next_r | clos_sel;
      if (accept_in) covered_r <= 1'b0;
      else if (cov_hit) covered_r <= 1'b1;
      // hold the beat fields
      if (accept_in) begin
        cp_r   <= f_cp;
        kind_r <= item_kind_t'(f_kind);
      end
      if (accept_in && f_kind == ITEM_LOAD_NODE && 32'(f_idx) < NODES)
        accmask_r[NW'(f_idx)] <= (f_nkind == NK_ACCEPT);
      // commit the new live set
      if (state_r == ST_CLOS && kind_r == ITEM_BEGIN)
        active_r <= (32'(start_r) < NODES) ? sc_q : '0;
      else if (state_r == ST_FOLD)
        active_r <= clos_pend_r ? (next_r | clos_sel) : next_r;
      if (state_r == ST_OUT) begin
        acc_r <= (active_r & accmask_r) != '0;
        cov_r <= (active_r == '0) ? COVER_NONE :
                 (covered_r || cov_hit) ? COVER_ALL : COVER_SOME;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept_in) state_nxt = ST_CLOS;
      ST_CLOS: state_nxt = (kind_r == ITEM_CHAR) ? ST_SCAN : ST_COVER;
      ST_SCAN: begin
        if (set_walk) state_nxt = ST_RNG;
        else if (last_node) state_nxt = ST_FOLD;
      end
      ST_RNG: if (r_done) state_nxt = last_node ? ST_FOLD : ST_SCAN;
      ST_FOLD: state_nxt = ST_COVER;
      ST_COVER: if (last_node) state_nxt = ST_OUT;
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'b0, cov_r, acc_r};

  // Ready only in idle, one-hot state, result raised from the output state
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r) == ST_OUT) else $error("stray result");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for glob_nfa_matcher.
// Fills the node and range tables completely, then runs phases under several
// start nodes: random table rewrites followed by begin/character runs whose
// characters are drawn from a few letters, the separator and random code points.
// A predictor steps its own copy of the automaton on every accepted beat and
// the monitor checks each result beat against the oldest prediction.
// Random bursts of idling on both sides, none in the final phase.
// ----------------------------------------------------------------------------
module tb;
  import gnm_pkg::*;

  localparam int N_NODES   = 64;
  localparam int N_RANGES  = 4;
  localparam int MAX_CYCLES = 5000000;

  typedef struct {
    item_kind_t  kind;
    logic [5:0]  node_index;
    node_kind_t  node_kind;
    logic [20:0] code_point;
    logic [5:0]  next_node;
    logic        negated;
    logic [2:0]  range_count;
    logic [1:0]  range_slot;
    logic [20:0] range_last;
    logic [63:0] closure_plain;
    logic [63:0] closure_start;
  } glob_beat_t;

  typedef struct {
    logic   accepted;
    cover_t cover_res;
  } match_status_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [199:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;
  logic         cfg_we;
  logic [5:0]   cfg_wdata;

  glob_nfa_matcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor copy of the automaton
  node_kind_t  m_kind   [N_NODES];
  logic [20:0] m_char   [N_NODES];
  logic [5:0]  m_succ   [N_NODES];
  logic        m_neg    [N_NODES];
  logic [2:0]  m_rcount [N_NODES];
  logic [63:0] m_plain  [N_NODES];
  logic [63:0] m_cstart [N_NODES];
  logic [20:0] m_rfirst [N_NODES*N_RANGES];
  logic [20:0] m_rlast  [N_NODES*N_RANGES];
  logic [63:0] live_set;
  logic [63:0] accept_set;
  logic [5:0]  start_idx;

  glob_beat_t    pending_beats[$];
  match_status_t status_q[$];
  glob_beat_t    cur_beat;
  int            fails;
  int            cycles;
  bit            quiet;
  int            in_gap;
  int            out_stall;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [199:0] pack_beat(glob_beat_t b);
    logic [199:0] d;
    d = '0;
    d[1:0]     = b.kind;
    d[7:2]     = b.node_index;
    d[10:8]    = b.node_kind;
    d[31:11]   = b.code_point;
    d[37:32]   = b.next_node;
    d[38]      = b.negated;
    d[41:39]   = b.range_count;
    d[43:42]   = b.range_slot;
    d[64:44]   = b.range_last;
    d[128:65]  = b.closure_plain;
    d[192:129] = b.closure_start;
    return d;
  endfunction

  function automatic bit set_hit(int n, logic [20:0] ch);
    bit hit;
    int at;
    hit = 1'b0;
    for (int r = 0; r < m_rcount[n]; r++) begin
      at = n * N_RANGES + r;
      if (ch >= m_rfirst[at] && ch <= m_rlast[at]) hit = 1'b1;
    end
    return (ch != SLASH_CP) && (hit != m_neg[n]);
  endfunction

  // Step the automaton on one beat and return the status it reports
  function automatic match_status_t step_automaton(glob_beat_t b);
    match_status_t st;
    logic [63:0] nxt;
    bit sep;
    bit m;
    int at;
    case (b.kind)
      ITEM_LOAD_NODE: begin
        m_kind[b.node_index]   = b.node_kind;
        m_char[b.node_index]   = b.code_point;
        m_succ[b.node_index]   = b.next_node;
        m_neg[b.node_index]    = b.negated;
        m_rcount[b.node_index] = (b.range_count > N_RANGES) ? 3'(N_RANGES) : b.range_count;
        m_plain[b.node_index]  = b.closure_plain;
        m_cstart[b.node_index] = b.closure_start;
        accept_set[b.node_index] = (b.node_kind == NK_ACCEPT);
      end
      ITEM_LOAD_RANGE: begin
        at = b.node_index * N_RANGES + b.range_slot;
        m_rfirst[at] = b.code_point;
        m_rlast[at]  = b.range_last;
      end
      ITEM_BEGIN: begin
        live_set = m_cstart[start_idx];
      end
      default: begin
        nxt = '0;
        sep = (b.code_point == SLASH_CP);
        for (int i = 0; i < N_NODES; i++) begin
          if (live_set[i]) begin
            case (m_kind[i])
              NK_LITERAL:      m = (b.code_point == m_char[i]);
              NK_ANY, NK_STAR: m = !sep;
              NK_RSTAR:        m = 1'b1;
              NK_SET:          m = set_hit(i, b.code_point);
              default:         m = 1'b0;
            endcase
            if (m) begin
              if (m_kind[i] == NK_STAR || m_kind[i] == NK_RSTAR)
                nxt |= sep ? m_cstart[i] : m_plain[i];
              else
                nxt |= sep ? m_cstart[m_succ[i]] : m_plain[m_succ[i]];
            end
          end
        end
        live_set = nxt;
      end
    endcase
    st.accepted  = |(live_set & accept_set);
    st.cover_res = (live_set == '0) ? COVER_NONE : COVER_SOME;
    for (int i = 0; i < N_NODES; i++) begin
      if (live_set[i] && m_kind[i] == NK_RSTAR && |(m_cstart[m_succ[i]] & accept_set))
        st.cover_res = COVER_ALL;
    end
    return st;
  endfunction

  // Driver: hold a beat until taken, advance from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        status_q.push_back(step_automaton(cur_beat));
        if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 12);
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0 || (in_tvalid && in_tready && !quiet && $urandom_range(0, 5) == 0)
            || pending_beats.size() == 0) begin
          in_tvalid <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
        end else begin
          cur_beat = pending_beats.pop_front();
          in_tdata  <= pack_beat(cur_beat);
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // Monitor: stall in bursts, check each result beat
  always @(posedge clk) begin
    match_status_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $time, out_tdata);
          fails++;
        end else begin
          want = status_q.pop_front();
          if (out_tdata[0] !== want.accepted) begin
            $display("%0t: accepted mismatch, expected %0d actual %0d",
                     $time, want.accepted, out_tdata[0]);
            fails++;
          end
          if (out_tdata[2:1] !== want.cover_res) begin
            $display("%0t: cover_res mismatch, expected %0d actual %0d",
                     $time, want.cover_res, out_tdata[2:1]);
            fails++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall  <= out_stall - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall  <= $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("FAIL glob_nfa_matcher");
      $finish;
    end
  end

  function automatic logic [63:0] rand_closure();
    logic [63:0] c;
    int sel;
    sel = $urandom_range(0, 29);
    c = '0;
    if (sel == 0) c = '1;
    else if (sel < 3) c = {$urandom, $urandom};
    else if (sel < 5) c = '0;
    else for (int k = $urandom_range(1, 4); k > 0; k--) c[$urandom_range(0, 63)] = 1'b1;
    return c;
  endfunction

  function automatic logic [20:0] rand_cp();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 21'($urandom_range(8'h61, 8'h65));
    if (sel < 7) return SLASH_CP;
    if (sel < 8) return 21'h10FFFF;
    return 21'($urandom_range(0, 21'h10FFFF));
  endfunction

  task automatic add_node(int n);
    glob_beat_t b;
    b = '{kind: ITEM_LOAD_NODE, node_kind: NK_LITERAL, default: '0};
    b.kind          = ITEM_LOAD_NODE;
    b.node_index    = 6'(n);
    b.node_kind     = node_kind_t'($urandom_range(0, 7));
    b.code_point    = rand_cp();
    b.next_node     = 6'($urandom_range(0, 63));
    b.negated       = 1'($urandom);
    b.range_count   = 3'($urandom_range(0, 7));
    b.range_slot    = 2'($urandom);
    b.range_last    = 21'($urandom_range(0, 21'h10FFFF));
    b.closure_plain = rand_closure();
    b.closure_start = rand_closure();
    pending_beats.push_back(b);
  endtask

  task automatic add_range(int n, int s);
    glob_beat_t b;
    int lo;
    int sel;
    b = '{kind: ITEM_LOAD_RANGE, node_kind: NK_LITERAL, default: '0};
    b.kind       = ITEM_LOAD_RANGE;
    b.node_index = 6'(n);
    b.range_slot = 2'(s);
    b.node_kind  = node_kind_t'($urandom_range(0, 7));
    b.next_node  = 6'($urandom);
    b.negated    = 1'($urandom);
    b.range_count = 3'($urandom);
    b.closure_plain = {$urandom, $urandom};
    b.closure_start = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    lo  = (sel < 6) ? $urandom_range(8'h20, 8'h66) : $urandom_range(0, 21'h10FFFF);
    b.code_point = 21'(lo);
    if (sel == 9) begin
      b.code_point = 21'h10FFFF;
      b.range_last = 21'h0;
    end else if (sel == 8) begin
      b.code_point = 21'h0;
      b.range_last = 21'h10FFFF;
    end else begin
      b.range_last = 21'((lo + $urandom_range(0, 40) > 21'h10FFFF) ? 21'h10FFFF
                                                           : lo + $urandom_range(0, 40));
    end
    pending_beats.push_back(b);
  endtask

  task automatic add_text(int len);
    glob_beat_t b;
    b = '{kind: ITEM_BEGIN, node_kind: NK_LITERAL, default: '0};
    b.kind = ITEM_BEGIN;
    b.code_point = 21'($urandom);
    pending_beats.push_back(b);
    for (int k = 0; k < len; k++) begin
      b.kind = ITEM_CHAR;
      b.code_point = rand_cp();
      pending_beats.push_back(b);
    end
  endtask

  task automatic drain_and_set(logic [5:0] v);
    while (pending_beats.size() != 0 || status_q.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    start_idx = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int budget;
    logic [5:0] starts[10];
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    fails     = 0;
    cycles    = 0;
    quiet     = 1'b0;
    live_set  = '0;
    accept_set = '0;
    start_idx = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every node and range entry so nothing is ever read unwritten
    for (int n = 0; n < N_NODES; n++) add_node(n);
    for (int n = 0; n < N_NODES; n++)
      for (int s = 0; s < N_RANGES; s++) add_range(n, s);
    // Directed: separator, extreme code points, empty and full texts
    add_text(0);
    add_text(6);
    pending_beats[pending_beats.size()-1].code_point = 21'h10FFFF;
    pending_beats[pending_beats.size()-2].code_point = 21'h0;
    pending_beats[pending_beats.size()-3].code_point = SLASH_CP;

    starts = '{6'd0, 6'd63, 6'd0, 6'd1, 6'd63, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
    for (int p = 2; p < 10; p++) starts[p] = 6'($urandom_range(0, 63));
    for (int p = 0; p < 10; p++) begin
      drain_and_set(starts[p]);
      if (p == 9) quiet = 1'b1;
      for (int k = 0; k < 10; k++) add_node($urandom_range(0, 63));
      for (int k = 0; k < 5; k++) add_range($urandom_range(0, 63), $urandom_range(0, 3));
      budget = 100;
      while (budget > 0) begin
        int len;
        len = $urandom_range(0, 12);
        add_text(len);
        budget -= len + 1;
      end
    end

    while (pending_beats.size() != 0 || status_q.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("PASS glob_nfa_matcher");
    end else begin
      $display("FAIL glob_nfa_matcher");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/gnm_pkg.sv
hw/rtl/glob_nfa_matcher.sv
tb/tb.sv
